// ===== src/sensor_packet_frame_queue_assert.svh =====
// Assertion macros shared by the frame queue RTL.
`ifndef SENSOR_PACKET_FRAME_QUEUE_ASSERT_SVH
`define SENSOR_PACKET_FRAME_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/spfq_pkg.sv =====
package spfq_pkg;

  // Frame geometry.
  localparam int FRAME_SAMPLES = 512;
  localparam int IDX_W         = 9;
  localparam int AXES          = 3;
  localparam int GROUPS        = 122;
  localparam int EDGE_LOW      = 12;
  localparam int EDGE_HIGH     = 500;
  localparam int ODD_OFFSET    = 244;
  localparam int SUB_LAST      = 5;

  // Transaction commands.
  typedef enum logic [1:0] {
    CMD_WORD    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  // Per-transaction result flags carried to the output stage.
  typedef struct packed {
    logic       read_hit;
    logic       read_valid;
    logic       frame_done;
    logic       packet_dropped;
    logic [2:0] frames_queued;
  } result_flags_t;

endpackage

// ===== src/sensor_packet_frame_queue.sv =====
// Sensor packet frame queue. Packet words, head-frame reads and head releases
// all arrive as transactions on the s_ stream and each one gives exactly one
// result transaction on the m_ stream. One transaction is taken every cycle
// when the output is not stalled; its result passes through the registered
// read data of the sample memory, which has a single write/read port, and
// then the output register. Frames live in a ring of QUEUE_FRAMES slots of
// three 512-sample axes each. The sample memory has no reset and no clearing
// pass; the edge indices 0..11 and 500..511 are never written and always
// read back as zero, so a completed frame shows zeroed edges. A command word
// of 3 and a stray sample word outside a packet give a result with every flag
// and the read data zero; frames_queued still reports the ring fill.
`include "sensor_packet_frame_queue_assert.svh"

module sensor_packet_frame_queue #(
  parameter int QUEUE_FRAMES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration register.
  input  logic        capture_enable_we,
  input  logic        capture_enable_wdata,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // packet_word[15:0], read_axis[17:16], read_index[26:18]
  input  logic [2:0]  s_tuser,   // command[1:0], first_word[2]
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // read_data[15:0], read_valid[16], frame_done[17],
                                 // packet_dropped[18], frames_queued[21:19]
);

  import spfq_pkg::*;

  localparam int SLOT_W    = (QUEUE_FRAMES > 1) ? $clog2(QUEUE_FRAMES) : 1;
  localparam int ROW_W     = $clog2(QUEUE_FRAMES * AXES);
  localparam int ADDR_W    = ROW_W + IDX_W;
  localparam int MEM_DEPTH = QUEUE_FRAMES * AXES * FRAME_SAMPLES;
  localparam int CNT_W     = (SLOT_W > 3) ? SLOT_W : 3;

  // Input field unpacking.
  logic               [1:0] in_cmd;
  logic signed       [15:0] in_word;
  logic                     in_first;
  logic               [1:0] in_axis;
  logic         [IDX_W-1:0] in_index;
  logic                     accept;

  assign in_cmd   = s_tuser[1:0];
  assign in_first = s_tuser[2];
  assign in_word  = s_tdata[15:0];
  assign in_axis  = s_tdata[17:16];
  assign in_index = s_tdata[26:18];
  assign accept   = s_tvalid && s_tready;

  // Control state.
  logic                     capture_enable;
  logic        [SLOT_W-1:0] head_slot, head_slot_next;
  logic        [SLOT_W-1:0] tail_slot, tail_slot_next;
  logic                     pkt_active, pkt_active_next;
  logic                     upper_half, upper_half_next;
  logic                     packet_accepted, packet_accepted_next;
  logic                     packet_completes, packet_completes_next;
  logic               [2:0] sub_cnt, sub_cnt_next;
  logic               [6:0] grp_cnt, grp_cnt_next;
  logic signed       [15:0] slot_sequence [QUEUE_FRAMES];

  // Combinational results of the current transaction.
  logic                     seq_we;
  logic                     mem_we;
  logic        [ADDR_W-1:0] mem_waddr;
  logic                     rd_en;
  logic        [ADDR_W-1:0] mem_raddr;
  logic                     frame_complete;
  result_flags_t            flags;

  // Helpers.
  logic        [SLOT_W-1:0] tail_inc;
  logic        [SLOT_W-1:0] head_inc;
  logic signed       [16:0] seq_plus_one;
  logic         [IDX_W-1:0] wr_index;
  logic               [1:0] wr_axis;
  logic         [ROW_W-1:0] wr_row;
  logic         [ROW_W-1:0] rd_row;
  logic        [SLOT_W-1:0] queue_diff;
  logic         [CNT_W-1:0] queue_ext;

  assign tail_inc = (tail_slot == SLOT_W'(QUEUE_FRAMES - 1)) ? '0 : tail_slot + 1'b1;
  assign head_inc = (head_slot == SLOT_W'(QUEUE_FRAMES - 1)) ? '0 : head_slot + 1'b1;
  assign seq_plus_one = {slot_sequence[tail_slot][15], slot_sequence[tail_slot]} + 17'sd1;

  // Deinterleave: sub-word 0..5 picks axis (sub/2) and pair member (sub bit 0).
  assign wr_axis  = sub_cnt[2:1];
  assign wr_index = IDX_W'(EDGE_LOW) + (upper_half ? IDX_W'(ODD_OFFSET) : '0)
                    + {1'b0, grp_cnt, 1'b0} + {{(IDX_W-1){1'b0}}, sub_cnt[0]};
  assign wr_row    = ROW_W'(tail_slot) * ROW_W'(AXES) + ROW_W'(wr_axis);
  assign mem_waddr = {wr_row, wr_index};
  assign rd_row    = ROW_W'(head_slot) * ROW_W'(AXES) + ROW_W'(in_axis);
  assign mem_raddr = {rd_row, in_index};

  // Frame count after this transaction, saturated at seven.
  always_comb begin
    if (tail_slot_next >= head_slot_next) begin
      queue_diff = tail_slot_next - head_slot_next;
    end else begin
      queue_diff = tail_slot_next + SLOT_W'(QUEUE_FRAMES) - head_slot_next;
    end
    queue_ext = CNT_W'(queue_diff);
  end

  // Next state and result flags.
  always_comb begin
    head_slot_next        = head_slot;
    tail_slot_next        = tail_slot;
    pkt_active_next       = pkt_active;
    upper_half_next       = upper_half;
    packet_accepted_next  = packet_accepted;
    packet_completes_next = packet_completes;
    sub_cnt_next          = sub_cnt;
    grp_cnt_next          = grp_cnt;
    seq_we                = 1'b0;
    mem_we                = 1'b0;
    rd_en                 = 1'b0;
    frame_complete        = 1'b0;
    flags.read_hit        = 1'b0;
    flags.read_valid      = 1'b0;
    flags.frame_done      = 1'b0;
    flags.packet_dropped  = 1'b0;
    if (accept) begin
      case (in_cmd)
        CMD_WORD: begin
          if (in_first) begin
            // Start of packet: decide drop and completion up front.
            upper_half_next       = in_word[0];
            packet_accepted_next  = capture_enable && (head_slot != tail_inc);
            packet_completes_next = in_word[0] && (seq_plus_one == 17'(in_word));
            seq_we                = packet_accepted_next && !packet_completes_next;
            pkt_active_next       = 1'b1;
            sub_cnt_next          = '0;
            grp_cnt_next          = '0;
            flags.packet_dropped  = !packet_accepted_next;
          end else if (pkt_active) begin
            if (packet_accepted) begin
              mem_we = 1'b1;
            end else begin
              flags.packet_dropped = 1'b1;
            end
            if (grp_cnt == 7'(GROUPS - 1) && sub_cnt == 3'(SUB_LAST)) begin
              pkt_active_next = 1'b0;
              if (packet_accepted && packet_completes) begin
                frame_complete   = 1'b1;
                tail_slot_next   = tail_inc;
                flags.frame_done = 1'b1;
              end
            end else if (sub_cnt == 3'(SUB_LAST)) begin
              sub_cnt_next = '0;
              grp_cnt_next = grp_cnt + 7'd1;
            end else begin
              sub_cnt_next = sub_cnt + 3'd1;
            end
          end
        end
        CMD_READ: begin
          if (head_slot != tail_slot && in_axis < 2'(AXES)) begin
            rd_en            = 1'b1;
            flags.read_valid = 1'b1;
            // Edge samples of a completed frame are zero.
            flags.read_hit   = (in_index >= IDX_W'(EDGE_LOW)) &&
                               (in_index < IDX_W'(EDGE_HIGH));
          end
        end
        CMD_RELEASE: begin
          if (head_slot != tail_slot) begin
            head_slot_next = head_inc;
          end
        end
        default: begin
        end
      endcase
    end
    flags.frames_queued = (queue_ext > CNT_W'(7)) ? 3'd7 : queue_ext[2:0];
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable   <= 1'b0;
      head_slot        <= '0;
      tail_slot        <= '0;
      pkt_active       <= 1'b0;
      upper_half       <= 1'b0;
      packet_accepted  <= 1'b0;
      packet_completes <= 1'b0;
      sub_cnt          <= '0;
      grp_cnt          <= '0;
      for (int i = 0; i < QUEUE_FRAMES; i++) begin
        slot_sequence[i] <= '0;
      end
    end else begin
      if (capture_enable_we) begin
        capture_enable <= capture_enable_wdata;
      end
      head_slot        <= head_slot_next;
      tail_slot        <= tail_slot_next;
      pkt_active       <= pkt_active_next;
      upper_half       <= upper_half_next;
      packet_accepted  <= packet_accepted_next;
      packet_completes <= packet_completes_next;
      sub_cnt          <= sub_cnt_next;
      grp_cnt          <= grp_cnt_next;
      if (seq_we) begin
        slot_sequence[tail_slot] <= in_word;
      end
    end
  end

  // Sample memory: one write or one read per transaction, registered read data.
  logic [15:0] sample_mem [MEM_DEPTH];
  logic [15:0] mem_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_mem[mem_waddr] <= in_word;
    end
    if (rd_en) begin
      mem_q <= sample_mem[mem_raddr];
    end
  end

  // Two-stage result pipeline: memory read stage, then output register.
  logic          p1_valid;
  result_flags_t p1_flags;
  logic          advance;
  logic [15:0]   p1_rdata;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !p1_valid || advance;
  assign p1_rdata = p1_flags.read_hit ? mem_q : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        p1_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= p1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_flags <= flags;
    end
    if (advance && p1_valid) begin
      m_tdata <= {2'b00, p1_flags.frames_queued, p1_flags.packet_dropped,
                  p1_flags.frame_done, p1_flags.read_valid, p1_rdata};
    end
  end

  // A completing packet always moves the tail.
  `SPFQ_ASSERT_NEXT(a_tail_moves, frame_complete, tail_slot != $past(tail_slot),
                    "frame completed without advancing tail")
  // A release on an empty ring leaves the head alone.
  `SPFQ_ASSERT_NEXT(a_empty_release,
                    accept && in_cmd == CMD_RELEASE && head_slot == tail_slot,
                    $stable(head_slot), "head moved on an empty ring")
  // Packet writes never land in the frame being read out.
  `SPFQ_ASSERT_NOW(a_no_head_write, mem_we && head_slot != tail_slot,
                   tail_slot != head_slot_next || head_slot_next == tail_slot_next,
                   "sample write into the head frame")
  // A word cannot both complete a frame and be dropped.
  `SPFQ_ASSERT_NOW(a_done_not_dropped, p1_valid,
                   !(p1_flags.frame_done && p1_flags.packet_dropped),
                   "frame done reported on a dropped packet")

endmodule

// ===== tb/sensor_packet_frame_queue_tb.sv =====
`timescale 1ns / 1ps

module sensor_packet_frame_queue_tb;
  import spfq_pkg::*;

  localparam int SLOTS           = 8;
  localparam int GROUP_WORDS     = SUB_LAST + 1;
  localparam int WORDS_PER_PKT   = 1 + GROUP_WORDS * GROUPS;
  localparam int STORE_DEPTH     = SLOTS * AXES * FRAME_SAMPLES;
  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 20;
  localparam int PHASES          = 6;
  localparam int SEQS_PER_PHASE  = 10;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [1:0] AXIS_BAD    = 2'd3;

  // One input transaction, unpacked.
  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] word;
    logic               first;
    logic [1:0]         axis;
    logic [8:0]         index;
  } queue_req_t;

  // One result transaction, unpacked.
  typedef struct packed {
    logic signed [15:0] read_data;
    logic               read_valid;
    logic               frame_done;
    logic               packet_dropped;
    logic [2:0]         frames_queued;
  } frame_result_t;

  // Kinds of rows in the directed plan.
  typedef enum {
    ROW_CFG, ROW_HOLD, ROW_PACKET, ROW_PAIR, ROW_READ, ROW_RELEASE, ROW_STRAY, ROW_UNKNOWN
  } step_kind_t;

  typedef struct {
    step_kind_t kind;
    int arg;        // capture value, sequence number or stray word
    int words;      // packet length in words
    int reps;
    int axis;       // -1 picks at random
    int index;      // -1 picks a defined sample at random
    int typed;      // nonzero when the first result below is given
    int e_data;
    int e_valid;
    int e_done;
    int e_dropped;
    int e_queued;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        capture_enable_we;
  logic        capture_enable_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  sensor_packet_frame_queue #(
    .QUEUE_FRAMES(SLOTS)
  ) i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .capture_enable_we    (capture_enable_we),
    .capture_enable_wdata (capture_enable_wdata),
    .s_tvalid             (s_tvalid),
    .s_tready             (s_tready),
    .s_tdata              (s_tdata),
    .s_tuser              (s_tuser),
    .m_tvalid             (m_tvalid),
    .m_tready             (m_tready),
    .m_tdata              (m_tdata)
  );

  always #5 clk = ~clk;

  // Mirror of the frame ring, kept in step with accepted transactions.
  logic [15:0]   mirror_data [STORE_DEPTH];
  bit            mirror_known [STORE_DEPTH];
  int            slot_numbers [SLOTS];
  int            oldest_slot = 0;
  int            fill_slot = 0;
  int            pkt_word_idx = 0;
  bit            pkt_is_odd = 1'b0;
  bit            pkt_kept = 1'b0;
  bit            pkt_finishes = 1'b0;
  bit            capture_on = 1'b0;

  frame_result_t pending_results [$];
  bit            typed_armed = 1'b0;
  frame_result_t typed_rsp;
  bit            hold_req = 1'b0;
  int            burst_left = 0;
  int            fail_count = 0;
  int            cycle_count = 0;
  int            items_sent = 0;
  int            frames_completed = 0;
  int            packets_dropped = 0;
  int            full_ring_drops = 0;
  int            reads_hit = 0;
  int            cfg_writes = 0;

  function automatic int sample_addr(input int slot, input int axis, input int idx);
    return (slot * AXES + axis) * FRAME_SAMPLES + idx;
  endfunction

  function automatic int frames_waiting();
    return (fill_slot - oldest_slot + SLOTS) % SLOTS;
  endfunction

  // Works out the result of one accepted transaction and advances the mirror.
  function automatic frame_result_t predict_queue_result(input queue_req_t r);
    frame_result_t res;
    int            seqv;
    int            k;
    int            addr;
    int            ax;
    int            i;
    int            n;
    res = '0;
    case (r.command)
      CMD_WORD: begin
        if (r.first) begin
          seqv = int'(r.word);
          pkt_is_odd = r.word[0];
          pkt_kept = capture_on && (oldest_slot != (fill_slot + 1) % SLOTS);
          pkt_finishes = pkt_is_odd && (slot_numbers[fill_slot] + 1 == seqv);
          if (pkt_kept && !pkt_finishes) begin
            slot_numbers[fill_slot] = seqv;
          end
          pkt_word_idx = 1;
          res.packet_dropped = !pkt_kept;
          if (!pkt_kept) begin
            packets_dropped++;
            if (capture_on) begin
              full_ring_drops++;
            end
          end
        end else if (pkt_word_idx != 0) begin
          if (pkt_kept) begin
            // Pairs land side by side: x0,x1 then y0,y1 then z0,z1 of one group.
            k = pkt_word_idx - 1;
            addr = sample_addr(fill_slot, (k % GROUP_WORDS) / 2,
                               EDGE_LOW + (pkt_is_odd ? ODD_OFFSET : 0) +
                               2 * (k / GROUP_WORDS) + k % 2);
            mirror_data[addr] = r.word;
            mirror_known[addr] = 1'b1;
          end else begin
            res.packet_dropped = 1'b1;
          end
          pkt_word_idx++;
          if (pkt_word_idx >= WORDS_PER_PKT) begin
            pkt_word_idx = 0;
            if (pkt_kept && pkt_finishes) begin
              // A completed frame shows zeros outside the captured span.
              for (ax = 0; ax < AXES; ax++) begin
                for (i = 0; i < FRAME_SAMPLES; i++) begin
                  if (i < EDGE_LOW || i >= EDGE_HIGH) begin
                    mirror_data[sample_addr(fill_slot, ax, i)] = '0;
                    mirror_known[sample_addr(fill_slot, ax, i)] = 1'b1;
                  end
                end
              end
              fill_slot = (fill_slot + 1) % SLOTS;
              res.frame_done = 1'b1;
              frames_completed++;
            end
          end
        end
      end
      CMD_READ: begin
        if (oldest_slot != fill_slot && r.axis < AXES) begin
          res.read_data = mirror_data[sample_addr(oldest_slot, r.axis, r.index)];
          res.read_valid = 1'b1;
          reads_hit++;
        end
      end
      CMD_RELEASE: begin
        if (oldest_slot != fill_slot) begin
          oldest_slot = (oldest_slot + 1) % SLOTS;
        end
      end
      default: begin
      end
    endcase
    n = frames_waiting();
    res.frames_queued = (n > 7) ? 3'd7 : 3'(n);
    return res;
  endfunction

  // A read is only defined on an empty ring, a bad axis or a written sample.
  function automatic bit read_is_defined(input int axis, input int idx);
    if (oldest_slot == fill_slot || axis >= AXES) begin
      return 1'b1;
    end
    return mirror_known[sample_addr(oldest_slot, axis, idx)];
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one transaction in sender bursts and records its expected result.
  task automatic send_item(input queue_req_t r);
    int            gap;
    frame_result_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 120);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, r.index, r.axis, r.word};
    s_tuser  <= {r.first, r.command};
    do @(posedge clk); while (!s_tready);
    want = predict_queue_result(r);
    if (typed_armed) begin
      want = typed_rsp;
      typed_armed = 1'b0;
    end
    pending_results.push_back(want);
    items_sent++;
  endtask

  // Sends a transaction whose unused fields carry random noise.
  task automatic send_plain(input logic [1:0] cmd, input logic first_bit,
                            input logic [15:0] word);
    queue_req_t r;
    r.command = cmd;
    r.first   = first_bit;
    r.word    = word;
    r.axis    = 2'($urandom);
    r.index   = 9'($urandom);
    send_item(r);
  endtask

  task automatic send_read(input int axis_sel, input int idx_sel);
    queue_req_t r;
    int         axis;
    int         idx;
    int         tries;
    axis = axis_sel;
    if (axis < 0) begin
      axis = ($urandom_range(0, 15) == 0) ? AXIS_BAD : $urandom_range(0, AXES - 1);
    end
    idx = idx_sel;
    if (idx < 0) begin
      idx = $urandom_range(0, FRAME_SAMPLES - 1);
      tries = 0;
      while (!read_is_defined(axis, idx) && tries < 8) begin
        idx = $urandom_range(0, FRAME_SAMPLES - 1);
        tries++;
      end
      // The zeroed edges of a completed frame are always defined.
      if (!read_is_defined(axis, idx)) begin
        idx = $urandom_range(0, 1) ? $urandom_range(0, EDGE_LOW - 1)
                                    : $urandom_range(EDGE_HIGH, FRAME_SAMPLES - 1);
      end
    end
    r.command = CMD_READ;
    r.first   = 1'($urandom);
    r.word    = 16'($urandom);
    r.axis    = 2'(axis);
    r.index   = 9'(idx);
    send_item(r);
  endtask

  // Sends a packet of the given length; mixed packets carry reads and releases.
  task automatic send_packet(input logic [15:0] seqv, input int words, input bit mixed);
    int w;
    send_plain(CMD_WORD, 1'b1, seqv);
    for (w = 1; w < words; w++) begin
      if (mixed && $urandom_range(0, 49) == 0) begin
        if ($urandom_range(0, 3) != 0) begin
          send_read(-1, -1);
        end else begin
          send_plain(CMD_RELEASE, 1'($urandom), 16'($urandom));
        end
      end
      send_plain(CMD_WORD, 1'b0, pick_sample());
    end
  endtask

  // An even packet and the odd one after it make one complete frame.
  task automatic send_pair(input bit mixed);
    logic [15:0] even_seq;
    even_seq = 16'($urandom) & 16'hFFFE;
    send_packet(even_seq, WORDS_PER_PKT, mixed);
    send_packet(even_seq + 16'd1, WORDS_PER_PKT, mixed);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capture(input bit on);
    wait_idle();
    capture_enable_we    <= 1'b1;
    capture_enable_wdata <= on;
    @(posedge clk);
    capture_enable_we    <= 1'b0;
    capture_on = on;
    cfg_writes++;
  endtask

  // Receiver: changing stall patterns plus long hold-offs on request.
  initial begin
    int mode;
    int span;
    int n;
    m_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 300);
      for (n = 0; n < span; n++) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom);
          default: m_tready <= (n % 4 == 0);
        endcase
      end
    end
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    frame_result_t seen;
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen.read_data      = m_tdata[15:0];
      seen.read_valid     = m_tdata[16];
      seen.frame_done     = m_tdata[17];
      seen.packet_dropped = m_tdata[18];
      seen.frames_queued  = m_tdata[21:19];
      if (pending_results.size() == 0) begin
        $error("Result transaction with no expectation waiting: %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (seen.read_data !== want.read_data) begin
          $error("read_data: expected %0d, got %0d", want.read_data, seen.read_data);
          fail_count++;
        end
        if (seen.read_valid !== want.read_valid) begin
          $error("read_valid: expected %0d, got %0d", want.read_valid, seen.read_valid);
          fail_count++;
        end
        if (seen.frame_done !== want.frame_done) begin
          $error("frame_done: expected %0d, got %0d", want.frame_done, seen.frame_done);
          fail_count++;
        end
        if (seen.packet_dropped !== want.packet_dropped) begin
          $error("packet_dropped: expected %0d, got %0d",
                 want.packet_dropped, seen.packet_dropped);
          fail_count++;
        end
        if (seen.frames_queued !== want.frames_queued) begin
          $error("frames_queued: expected %0d, got %0d",
                 want.frames_queued, seen.frames_queued);
          fail_count++;
        end
      end
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding.", pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Main sequence: reset, directed plan, then random phases.
  initial begin
    plan_row_t plan [$];
    int        i;
    int        ph;
    int        s;
    int        pick;
    rst                  = 1'b1;
    capture_enable_we    = 1'b0;
    capture_enable_wdata = 1'b0;
    s_tvalid             = 1'b0;
    s_tdata              = '0;
    s_tuser              = '0;
    foreach (slot_numbers[j]) slot_numbers[j] = 0;
    foreach (mirror_known[j]) mirror_known[j] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // kind, arg, words, reps, axis, index, typed, data, valid, done, dropped, queued
    plan.push_back('{ROW_READ,    0, 0, 1, 0, 0,     1, 0, 0, 0, 0, 0});
    plan.push_back('{ROW_RELEASE, 0, 0, 1, 0, 0,     1, 0, 0, 0, 0, 0});
    plan.push_back('{ROW_UNKNOWN, 0, 0, 1, 0, 0,     1, 0, 0, 0, 0, 0});
    plan.push_back('{ROW_STRAY,   32767, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0});
    plan.push_back('{ROW_READ,    0, 0, 1, 3, 511,   1, 0, 0, 0, 0, 0});
    // Capture is off after reset, so the whole packet is dropped.
    plan.push_back('{ROW_PACKET,  4, WORDS_PER_PKT, 1, 0, 0, 1, 0, 0, 0, 1, 0});
    plan.push_back('{ROW_CFG,     1, 0, 1, 0, 0,     0, 0, 0, 0, 0, 0});
    // A negative pair completes the first frame.
    plan.push_back('{ROW_PACKET,  -2, WORDS_PER_PKT, 1, 0, 0, 0, 0, 0, 0, 0, 0});
    plan.push_back('{ROW_PACKET,  -1, WORDS_PER_PKT, 1, 0, 0, 0, 0, 0, 0, 0, 0});
    plan.push_back('{ROW_READ,    0, 0, 1, 0, 0,     1, 0, 1, 0, 0, 1});
    plan.push_back('{ROW_READ,    0, 0, 1, 2, 511,   1, 0, 1, 0, 0, 1});
    plan.push_back('{ROW_READ,    0, 0, 1, 3, 0,     1, 0, 0, 0, 0, 1});
    plan.push_back('{ROW_READ,    0, 0, 16, -1, -1,  0, 0, 0, 0, 0, 0});
    // The largest number is stored, then a cut-off even packet is abandoned
    // and its number still lets the next odd packet complete.
    plan.push_back('{ROW_PACKET,  32767, WORDS_PER_PKT, 1, 0, 0, 0, 0, 0, 0, 0, 0});
    plan.push_back('{ROW_PACKET,  6, 100, 1, 0, 0,   0, 0, 0, 0, 0, 0});
    plan.push_back('{ROW_PACKET,  7, WORDS_PER_PKT, 1, 0, 0, 0, 0, 0, 0, 0, 0});
    // Fill the ring under a long output stall; the next packet finds it full.
    plan.push_back('{ROW_HOLD,    0, 0, 1, 0, 0,     0, 0, 0, 0, 0, 0});
    plan.push_back('{ROW_PAIR,    0, 0, 5, 0, 0,     0, 0, 0, 0, 0, 0});
    plan.push_back('{ROW_PACKET,  8, WORDS_PER_PKT, 1, 0, 0, 1, 0, 0, 0, 1, 7});
    plan.push_back('{ROW_READ,    0, 0, 8, -1, -1,   0, 0, 0, 0, 0, 0});
    plan.push_back('{ROW_RELEASE, 0, 0, 7, 0, 0,     0, 0, 0, 0, 0, 0});
    plan.push_back('{ROW_RELEASE, 0, 0, 1, 0, 0,     1, 0, 0, 0, 0, 0});

    for (i = 0; i < plan.size(); i++) begin
      typed_armed = plan[i].typed != 0;
      typed_rsp.read_data      = 16'(plan[i].e_data);
      typed_rsp.read_valid     = 1'(plan[i].e_valid);
      typed_rsp.frame_done     = 1'(plan[i].e_done);
      typed_rsp.packet_dropped = 1'(plan[i].e_dropped);
      typed_rsp.frames_queued  = 3'(plan[i].e_queued);
      case (plan[i].kind)
        ROW_CFG:     set_capture(plan[i].arg != 0);
        ROW_HOLD:    hold_req = 1'b1;
        ROW_PACKET:  send_packet(16'(plan[i].arg), plan[i].words, 1'b0);
        ROW_PAIR:    repeat (plan[i].reps) send_pair(1'b0);
        ROW_READ:    repeat (plan[i].reps) send_read(plan[i].axis, plan[i].index);
        ROW_RELEASE: repeat (plan[i].reps) send_plain(CMD_RELEASE, 1'($urandom), 16'($urandom));
        ROW_STRAY:   send_plain(CMD_WORD, 1'b0, 16'(plan[i].arg));
        default:     send_plain(CMD_UNKNOWN, 1'($urandom), 16'($urandom));
      endcase
    end

    // Random phases, capture switched between them while idle.
    for (ph = 0; ph < PHASES; ph++) begin
      set_capture(ph % 3 != 2);
      for (s = 0; s < SEQS_PER_PHASE; s++) begin
        if (frames_waiting() >= $urandom_range(2, 7)) begin
          repeat ($urandom_range(1, 12)) send_read(-1, -1);
          send_plain(CMD_RELEASE, 1'($urandom), 16'($urandom));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 55) begin
            send_pair(1'b1);
          end else if (pick < 65) begin
            send_packet(16'($urandom), WORDS_PER_PKT, 1'b1);
          end else if (pick < 75) begin
            send_packet(16'($urandom), $urandom_range(1, WORDS_PER_PKT - 1), 1'b1);
          end else if (pick < 87) begin
            repeat ($urandom_range(1, 20)) send_read(-1, -1);
          end else if (pick < 93) begin
            repeat ($urandom_range(1, 2)) send_plain(CMD_RELEASE, 1'($urandom), 16'($urandom));
          end else if (pick < 98) begin
            send_plain(CMD_WORD, 1'b0, 16'($urandom));
            send_plain(CMD_UNKNOWN, 1'($urandom), 16'($urandom));
            send_read(AXIS_BAD, $urandom_range(0, FRAME_SAMPLES - 1));
          end else begin
            hold_req = 1'b1;
            send_pair(1'b1);
          end
        end
      end
    end

    // Drain, then give the block time to show any stray result.
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d transactions: %0d frames completed, %0d packets dropped, %0d reads hit.",
             items_sent, frames_completed, packets_dropped, reads_hit);
    $display("Capture was written %0d times and %0d packets met a full ring.",
             cfg_writes, full_ring_drops);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
